// ===== src/ftbg_pkg.sv =====
`default_nettype none

package ftbg_pkg;

    localparam int SAMPLE_RATE     = 48000;
    localparam int MAX_BURST       = 64;
    localparam int SINE_INDEX_BITS = 10;

    localparam int HZ_W    = 12;
    localparam int PIX_W   = 8;
    localparam int CNT_W   = 7;
    localparam int SAMP_W  = 8;
    localparam int PHASE_W = 32;
    localparam int AMP_W   = 7;

    // Numerator of the step: black*255 + span*pixel, or tone*255
    localparam int NUM_MAX = 2 * ((1 << HZ_W) - 1) * 255;
    localparam int NUM_W   = $clog2(NUM_MAX + 1);

    localparam int DIV_PIX = SAMPLE_RATE * 255;
    localparam int DIV_W   = $clog2(DIV_PIX + 1);
    // remainder before correction lies below twice the divisor
    localparam int REM_W   = DIV_W + 1;

    // Reciprocal scaled so that the estimate is at most one below the quotient
    localparam int          RECIP_SH = NUM_W + PHASE_W;
    localparam logic [63:0] RECIP    = (64'd1 << RECIP_SH) / 64'(DIV_PIX);
    localparam int          RECIP_W  = $clog2(RECIP + 64'd1);
    localparam int          PROD_W   = NUM_W + RECIP_W;

    localparam int QUARTER   = 1 << (SINE_INDEX_BITS - 2);
    localparam int QIDX_W    = SINE_INDEX_BITS - 2;
    localparam int AMP_MAX   = 127;
    localparam int MID_LEVEL = 128;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_BLACK_HZ = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPAN_HZ  = 1'd1;

    localparam logic [HZ_W-1:0] BLACK_HZ_RST = 12'd1500;
    localparam logic [HZ_W-1:0] SPAN_HZ_RST  = 12'd800;

    typedef struct packed {
        logic [PHASE_W-1:0] step;
        logic [CNT_W-1:0]   count;
    } t_seg;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_MUL,
        FS_REM,
        FS_FIX,
        FS_PUSH
    } t_front_state;

    typedef logic [AMP_W-1:0] t_qtab [QUARTER];

    // trunc(127*sin(pi/2 * r / QUARTER)) from a Q30 Taylor series
    function automatic logic [AMP_W-1:0] quarter_amp(input int r);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        v;
        if (r == 0) begin
            return '0;
        end
        x    = (64'(r) * HALF_PI_Q30) / QUARTER;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        // odd powers alternate in sign; divide by (2n)(2n+1)
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd272;
        sum  = sum + signed'(term);
        term = ((term * x2) >> 30) / 64'd342;
        sum  = sum - signed'(term);
        term = ((term * x2) >> 30) / 64'd420;
        sum  = sum + signed'(term);
        if (sum < 0) begin
            sum = 0;
        end
        v = (64'(sum) * 64'd127) >> 30;
        if (v > 64'd127) begin
            v = 64'd127;
        end
        return v[AMP_W-1:0];
    endfunction

    function automatic t_qtab build_qtab();
        t_qtab t;
        for (int i = 0; i < QUARTER; i++) begin
            t[i] = quarter_amp(i);
        end
        return t;
    endfunction

    localparam t_qtab QTAB = build_qtab();

    // Sample for a sine index: 128 plus the signed amplitude
    function automatic logic [SAMP_W-1:0] sine_sample(
        input logic [SINE_INDEX_BITS-1:0] idx
    );
        logic [1:0]        quad;
        logic [QIDX_W-1:0] rem;
        logic [QIDX_W-1:0] mirror;
        logic [AMP_W-1:0]  amp;
        quad   = idx[SINE_INDEX_BITS-1 -: 2];
        rem    = idx[QIDX_W-1:0];
        mirror = QIDX_W'(QUARTER - int'(rem));
        if (quad[0] == 1'b0) begin
            amp = QTAB[rem];
        end else if (rem == '0) begin
            amp = AMP_W'(AMP_MAX);
        end else begin
            amp = QTAB[mirror];
        end
        if (quad[1]) begin
            return SAMP_W'(MID_LEVEL) - SAMP_W'(amp);
        end
        return SAMP_W'(MID_LEVEL) + SAMP_W'(amp);
    endfunction

endpackage

`default_nettype wire

// ===== src/fm_tone_burst_generator_top.sv =====
// Channel   Direction  Handshake               Payload
// config    in         i_cfg_we                i_cfg_index, i_cfg_data
// segment   in         i_in_valid / o_in_stall func, tone_hz, pixel, sample_count
// sample    out        o_out_valid / i_out_stall sample, last
//
// The front takes a segment and works out its phase step by reciprocal multiplication
// with one correction step in states MUL, REM and FIX, then queues it in state PUSH.
// The back emits one sample a cycle unless stalled, from a 32-bit phase accumulator and a
// quarter-wave sine table; a two-deep queue lets the next step be ready as a burst ends.
// The front stalls new segments until the current one is queued.
// Reset is synchronous and clears the accumulator; an output stall freezes the back only.
`default_nettype none

module fm_tone_burst_generator_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ftbg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ftbg_pkg::HZ_W-1:0]      i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_in_func,
    input  wire logic [ftbg_pkg::HZ_W-1:0]      i_in_tone_hz,
    input  wire logic [ftbg_pkg::PIX_W-1:0]     i_in_pixel,
    input  wire logic [ftbg_pkg::CNT_W-1:0]     i_in_sample_count,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [ftbg_pkg::SAMP_W-1:0]         o_out_sample,
    output logic                                o_out_last
);
    import ftbg_pkg::*;

    logic push, full, pop, seg_valid;
    t_seg push_seg, seg;

    ftbg_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_in_func         (i_in_func),
        .i_in_tone_hz      (i_in_tone_hz),
        .i_in_pixel        (i_in_pixel),
        .i_in_sample_count (i_in_sample_count),
        .o_push            (push),
        .o_push_seg        (push_seg),
        .i_full            (full)
    );

    ftbg_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_seg (push_seg),
        .o_full     (full),
        .i_pop      (pop),
        .o_valid    (seg_valid),
        .o_seg      (seg)
    );

    ftbg_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_seg_valid  (seg_valid),
        .i_seg        (seg),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_sample (o_out_sample),
        .o_out_last   (o_out_last)
    );

endmodule

`default_nettype wire

// ===== src/ftbg_front.sv =====
`default_nettype none

module ftbg_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [ftbg_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ftbg_pkg::HZ_W-1:0]      i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_in_func,
    input  wire logic [ftbg_pkg::HZ_W-1:0]      i_in_tone_hz,
    input  wire logic [ftbg_pkg::PIX_W-1:0]     i_in_pixel,
    input  wire logic [ftbg_pkg::CNT_W-1:0]     i_in_sample_count,
    output logic                                o_push,
    output ftbg_pkg::t_seg                      o_push_seg,
    input  wire logic                           i_full
);
    import ftbg_pkg::*;

    t_front_state       r_state, n_state;
    logic [HZ_W-1:0]    r_black, r_span;
    logic [NUM_W-1:0]   r_num, n_num;
    logic [PHASE_W-1:0] r_quo, n_quo;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    logic                  accept;
    logic [HZ_W+7:0]       black_term;
    logic [HZ_W+7:0]       tone_term;
    logic [HZ_W+PIX_W-1:0] span_term;
    logic [NUM_W-1:0]      num;
    logic [PROD_W-1:0]     prod;
    logic [REM_W-1:0]      back_prod;

    assign accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != FS_IDLE);

    // times 255 as a shift and a subtract; a tone is scaled by 255 too
    assign black_term = {r_black, 8'd0} - {8'd0, r_black};
    assign tone_term  = {i_in_tone_hz, 8'd0} - {8'd0, i_in_tone_hz};
    assign span_term  = (HZ_W+PIX_W)'(r_span) * (HZ_W+PIX_W)'(i_in_pixel);

    assign num = i_in_func ? NUM_W'(black_term) + NUM_W'(span_term)
                           : NUM_W'(tone_term);

    assign prod      = PROD_W'(r_num) * PROD_W'(RECIP);
    // the dividend has 32 zero low bits, so the remainder is minus this product
    assign back_prod = r_quo[REM_W-1:0] * REM_W'(DIV_PIX);

    assign o_push           = (r_state == FS_PUSH);
    assign o_push_seg.step  = r_quo;
    assign o_push_seg.count = r_cnt;

    always_comb begin
        n_state = r_state;
        n_num   = r_num;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        unique case (r_state)
            FS_IDLE: begin
                // drop items with no samples: the step they set is never used
                if (accept && i_in_sample_count != '0) begin
                    n_state = FS_MUL;
                    n_num   = num;
                    n_cnt   = (i_in_sample_count > CNT_W'(MAX_BURST))
                              ? CNT_W'(MAX_BURST) : i_in_sample_count;
                end
            end
            FS_MUL: begin
                n_quo   = PHASE_W'(prod >> NUM_W);
                n_state = FS_REM;
            end
            FS_REM: begin
                n_rem   = '0 - back_prod;
                n_state = FS_FIX;
            end
            FS_FIX: begin
                // estimate is at most one short
                if (r_rem >= REM_W'(DIV_PIX)) begin
                    n_quo = r_quo + PHASE_W'(1);
                end
                n_state = FS_PUSH;
            end
            FS_PUSH: begin
                if (!i_full) begin
                    n_state = FS_IDLE;
                end
            end
            default: n_state = FS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
            r_black <= BLACK_HZ_RST;
            r_span  <= SPAN_HZ_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_BLACK_HZ: r_black <= i_cfg_data;
                    REG_SPAN_HZ:  r_span  <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_cnt <= n_cnt;
    end

endmodule

`default_nettype wire

// ===== src/ftbg_fifo.sv =====
`default_nettype none

module ftbg_fifo (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire ftbg_pkg::t_seg i_push_seg,
    output logic         o_full,
    input  wire logic    i_pop,
    output logic         o_valid,
    output ftbg_pkg::t_seg o_seg
);
    import ftbg_pkg::*;

    t_seg       r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_fill;
    logic       do_push, do_pop;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_seg   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_fill <= r_fill + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_seg;
        end
    end

endmodule

`default_nettype wire

// ===== src/ftbg_back.sv =====
`default_nettype none

module ftbg_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_seg_valid,
    input  wire ftbg_pkg::t_seg              i_seg,
    output logic                             o_pop,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [ftbg_pkg::SAMP_W-1:0]      o_out_sample,
    output logic                             o_out_last
);
    import ftbg_pkg::*;

    logic [PHASE_W-1:0]         r_phase, r_step;
    logic [CNT_W-1:0]           r_left;
    logic                       r_out_valid;
    logic [SINE_INDEX_BITS-1:0] r_idx;
    logic                       r_last;
    logic [PHASE_W-1:0]         n_phase;
    logic                       emit;

    assign emit    = (r_left != '0) && (!r_out_valid || !i_out_stall);
    // fetch the next segment as the current one issues its final sample
    assign o_pop   = i_seg_valid && ((r_left == '0) || (emit && r_left == CNT_W'(1)));
    assign n_phase = r_phase + r_step;

    assign o_out_valid  = r_out_valid;
    assign o_out_sample = sine_sample(r_idx);
    assign o_out_last   = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_step      <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_phase     <= n_phase;
                r_out_valid <= 1'b1;
                r_left      <= r_left - 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_step <= i_seg.step;
                r_left <= i_seg.count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_idx  <= n_phase[PHASE_W-1 -: SINE_INDEX_BITS];
            r_last <= (r_left == CNT_W'(1));
        end
    end

endmodule

`default_nettype wire

// ===== src/ftbg_checker.sv =====
`default_nettype none

module ftbg_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_stall,
    input wire logic [ftbg_pkg::CNT_W-1:0]     i_in_sample_count,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire logic [ftbg_pkg::SAMP_W-1:0]    o_out_sample,
    input wire logic                           o_out_last
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_sample) && $stable(o_out_last))
        else $error("stalled output item changed");

    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_sample_count != '0 |=> o_in_stall)
        else $error("front took no time over a segment");

    a_sample_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_sample != '0)
        else $error("sample below the sine range");

endmodule

bind fm_tone_burst_generator_top ftbg_checker u_ftbg_checker (.*);

`default_nettype wire
